/* hdl/dqz_pkg.sv */
// dqz_pkg: shared types, constants and helper functions of the dq0 frame transform
// no dependencies; used by every module in hdl
`timescale 1ns / 1ps
package dqz_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ANGLE_W      = 16;
  localparam int GAIN_W       = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int PHASE_W      = 32;
  localparam int XY_W         = 34;
  localparam int Z_W          = 32;
  localparam int P_W          = SAMPLE_W + 4;
  localparam int COEF_W       = 17;
  localparam int SUM_W        = P_W + COEF_W + 3;
  localparam int R_W          = SUM_W - 15;
  localparam int ADDR_W       = 3;
  localparam int LATENCY      = CORDIC_STEPS + 6;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);
  localparam logic [ANGLE_W-1:0] THIRD_TURN = ANGLE_W'(((1 << (ANGLE_W + 1)) + 3) / 6);

  localparam logic signed [COEF_W-1:0] COEF_HALF      = 17'sd16384;
  localparam logic signed [COEF_W-1:0] COEF_SQRT3_2   = 17'sd28378;
  localparam logic signed [COEF_W-1:0] COEF_INV_SQRT2 = 17'sd23170;
  localparam logic signed [COEF_W-1:0] COEF_ONE       = 17'sd32768;
  localparam logic signed [XY_W-1:0]   CORDIC_X0      = 34'sd652032874;
  localparam logic [PHASE_W-1:0]       EIGHTH_TURN    = 32'h2000_0000;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [0:0] REG_GAIN = 1'b0;

  typedef enum logic [2:0] {
    OP_CLARKE = 3'd0,
    OP_PARK   = 3'd1,
    OP_IPARK  = 3'd2,
    OP_DQZ    = 3'd3,
    OP_IDQZ   = 3'd4
  } dqz_op_t;

  typedef struct packed {
    logic [2:0]                 operation;
    logic [ANGLE_W-1:0]         angle;
    logic signed [SAMPLE_W-1:0] in_first;
    logic signed [SAMPLE_W-1:0] in_second;
    logic signed [SAMPLE_W-1:0] in_third;
  } dqz_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_first;
    logic signed [SAMPLE_W-1:0] out_second;
    logic signed [SAMPLE_W-1:0] out_third;
    logic                       clipped;
  } dqz_out_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
  } dqz_lane_t;

  typedef struct packed {
    logic                  vld;
    logic [2:0]            op;
    logic signed [P_W-1:0] p0;
    logic signed [P_W-1:0] p1;
    logic signed [P_W-1:0] p2;
    dqz_lane_t [2:0]       lane;
  } dqz_cord_t;

  function automatic logic signed [Z_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] a;
    case (i)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10679838;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41722;
      5'd15:   a = 32'sd20861;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      default: a = '0;
    endcase
    return a;
  endfunction

  // round half up, then drop s fraction bits
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    logic signed [63:0] h;
    h = 64'sd1 <<< (s - 1);
    return (v + h) >>> s;
  endfunction

  function automatic logic signed [COEF_W-1:0] clamp_coef(input logic signed [63:0] v);
    logic signed [COEF_W-1:0] r;
    if (v > 64'sd32768) begin
      r = COEF_ONE;
    end else if (v < -64'sd32768) begin
      r = -COEF_ONE;
    end else begin
      r = COEF_W'(v);
    end
    return r;
  endfunction

endpackage

/* hdl/dqz_frame_transform_core.sv */
// dqz_frame_transform_core: clarke, park, inverse park, dq0 and inverse dq0 transforms
// depends on dqz_pkg, dqz_clarke_front, dqz_cordic_cell, dqz_rotate_back
// Takes one sample set per clock (busy is never raised); each result passes through
// three front stages (input, clarke sums, gain and angle fold), an 18-cell cordic
// chain that computes three sine/cosine pairs side by side, and three back stages
// (unfold, rotation products, gain and saturation). out_valid marks each result for
// one cycle; the receiver cannot stall, so results must be taken as they appear.
// Write gain only while idle.
`timescale 1ns / 1ps
module dqz_frame_transform_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  dqz_pkg::dqz_in_t              in_data,
  output logic                          out_valid,
  output dqz_pkg::dqz_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dqz_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [dqz_pkg::GAIN_W-1:0] gain_r;
  logic [dqz_pkg::GAIN_W-1:0] gain_nxt;
  dqz_pkg::dqz_cord_t chain [dqz_pkg::CORDIC_STEPS+1];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_comb begin
    gain_nxt = gain_r;
    if (psel && penable && pwrite && paddr[2] == dqz_pkg::REG_GAIN) begin
      gain_nxt = pwdata[dqz_pkg::GAIN_W-1:0];
    end
    prdata = (paddr[2] == dqz_pkg::REG_GAIN) ? 32'(gain_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= dqz_pkg::GAIN_RESET;
    end else begin
      gain_r <= gain_nxt;
    end
  end

  dqz_clarke_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .gain    (gain_r),
    .chain_o (chain[0])
  );

  for (genvar i = 0; i < dqz_pkg::CORDIC_STEPS; i++) begin : g_cell
    dqz_cordic_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .step   (dqz_pkg::STEP_W'(i)),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  dqz_rotate_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .chain_i   (chain[dqz_pkg::CORDIC_STEPS]),
    .gain      (gain_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(dqz_pkg::LATENCY) out_valid)
    else $error("result missing after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##(dqz_pkg::LATENCY) !out_valid)
    else $error("result without transfer");

  a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (in_data.operation > dqz_pkg::OP_IDQZ)) |-> ##(dqz_pkg::LATENCY)
    (out_data.out_first == '0 && out_data.out_second == '0 &&
     out_data.out_third == '0 && !out_data.clipped))
    else $error("unused operation gave nonzero result");

  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clipped) |->
    (out_data.out_first == dqz_pkg::SAMPLE_MAX || out_data.out_first == dqz_pkg::SAMPLE_MIN ||
     out_data.out_second == dqz_pkg::SAMPLE_MAX || out_data.out_second == dqz_pkg::SAMPLE_MIN ||
     out_data.out_third == dqz_pkg::SAMPLE_MAX || out_data.out_third == dqz_pkg::SAMPLE_MIN))
    else $error("clip flag without saturated component");

endmodule

/* hdl/dqz_clarke_front.sv */
// dqz_clarke_front: input register, clarke sums with gain, operand select and angle fold
// depends on dqz_pkg; feeds the first cordic cell
`timescale 1ns / 1ps
module dqz_clarke_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  dqz_pkg::dqz_in_t              in_data,
  input  logic [dqz_pkg::GAIN_W-1:0]    gain,
  output dqz_pkg::dqz_cord_t            chain_o
);

  logic                           s1_vld_r;
  dqz_pkg::dqz_in_t               s1_r;
  logic                           s2_vld_r;
  dqz_pkg::dqz_in_t               s2_r;
  logic signed [dqz_pkg::P_W-1:0] cl_r [3];
  logic signed [dqz_pkg::P_W-1:0] cl_nxt [3];
  dqz_pkg::dqz_cord_t             s3_r;
  dqz_pkg::dqz_cord_t             s3_nxt;

  logic signed [33:0] acc0, acc1, acc2;
  logic signed [dqz_pkg::SAMPLE_W:0]   dif;
  logic signed [dqz_pkg::SAMPLE_W+1:0] tot;
  logic signed [dqz_pkg::P_W+dqz_pkg::GAIN_W:0] gp [3];
  logic signed [dqz_pkg::P_W-1:0] g [3];
  logic [dqz_pkg::ANGLE_W-1:0] ang [3];
  logic [dqz_pkg::PHASE_W-1:0] ph [3];
  logic [dqz_pkg::PHASE_W-1:0] t [3];
  logic use_clarke;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_r.vld <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      s3_r     <= s3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= in_data;
    s2_r <= s1_r;
    cl_r <= cl_nxt;
  end

  // clarke sums in q.15, rounded
  always_comb begin
    acc0 = (34'(s1_r.in_first) <<< 15) - (34'(s1_r.in_second) <<< 14)
         - (34'(s1_r.in_third) <<< 14);
    dif  = 17'(s1_r.in_second) - 17'(s1_r.in_third);
    tot  = 18'(s1_r.in_first) + 18'(s1_r.in_second) + 18'(s1_r.in_third);
    acc1 = dif * dqz_pkg::COEF_SQRT3_2;
    acc2 = tot * dqz_pkg::COEF_INV_SQRT2;
    cl_nxt[0] = dqz_pkg::P_W'(dqz_pkg::rnd(64'(acc0), 15));
    cl_nxt[1] = dqz_pkg::P_W'(dqz_pkg::rnd(64'(acc1), 15));
    cl_nxt[2] = dqz_pkg::P_W'(dqz_pkg::rnd(64'(acc2), 15));
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gp[k] = cl_r[k] * $signed({1'b0, gain});
      g[k]  = dqz_pkg::P_W'(dqz_pkg::rnd(64'(gp[k]), 14));
    end
    use_clarke = (s2_r.operation == dqz_pkg::OP_CLARKE) ||
                 (s2_r.operation == dqz_pkg::OP_DQZ);
    s3_nxt.vld = s2_vld_r;
    s3_nxt.op  = s2_r.operation;
    s3_nxt.p0  = use_clarke ? g[0] : dqz_pkg::P_W'(s2_r.in_first);
    s3_nxt.p1  = use_clarke ? g[1] : dqz_pkg::P_W'(s2_r.in_second);
    s3_nxt.p2  = use_clarke ? g[2] : dqz_pkg::P_W'(s2_r.in_third);
    ang[0] = (s2_r.operation == dqz_pkg::OP_IPARK) ? dqz_pkg::ANGLE_W'(0) - s2_r.angle
                                                   : s2_r.angle;
    ang[1] = s2_r.angle - dqz_pkg::THIRD_TURN;
    ang[2] = s2_r.angle + dqz_pkg::THIRD_TURN;
    for (int k = 0; k < 3; k++) begin
      ph[k] = dqz_pkg::PHASE_W'(ang[k]) << (dqz_pkg::PHASE_W - dqz_pkg::ANGLE_W);
      t[k]  = ph[k] + dqz_pkg::EIGHTH_TURN;
      s3_nxt.lane[k].quad = t[k][dqz_pkg::PHASE_W-1 -: 2];
      s3_nxt.lane[k].z    = $signed({2'b00, t[k][dqz_pkg::PHASE_W-3:0]})
                          - $signed(dqz_pkg::EIGHTH_TURN);
      s3_nxt.lane[k].x    = dqz_pkg::CORDIC_X0;
      s3_nxt.lane[k].y    = '0;
    end
  end

  assign chain_o = s3_r;

endmodule

/* hdl/dqz_cordic_cell.sv */
// dqz_cordic_cell: one cordic micro-rotation for three angle lanes, payload passed along
// depends on dqz_pkg; instantiated as a chain in the top level
`timescale 1ns / 1ps
module dqz_cordic_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dqz_pkg::STEP_W-1:0]        step,
  input  dqz_pkg::dqz_cord_t                cell_i,
  output dqz_pkg::dqz_cord_t                cell_o
);

  dqz_pkg::dqz_cord_t cell_r;
  dqz_pkg::dqz_cord_t cell_nxt;
  logic signed [dqz_pkg::XY_W-1:0] sx [3];
  logic signed [dqz_pkg::XY_W-1:0] sy [3];
  logic signed [dqz_pkg::Z_W-1:0]  at;

  always_comb begin
    cell_nxt = cell_i;
    at = dqz_pkg::atan_turn(step);
    for (int k = 0; k < 3; k++) begin
      sx[k] = cell_i.lane[k].x >>> step;
      sy[k] = cell_i.lane[k].y >>> step;
      if (!cell_i.lane[k].z[dqz_pkg::Z_W-1]) begin
        cell_nxt.lane[k].x = cell_i.lane[k].x - sy[k];
        cell_nxt.lane[k].y = cell_i.lane[k].y + sx[k];
        cell_nxt.lane[k].z = cell_i.lane[k].z - at;
      end else begin
        cell_nxt.lane[k].x = cell_i.lane[k].x + sy[k];
        cell_nxt.lane[k].y = cell_i.lane[k].y - sx[k];
        cell_nxt.lane[k].z = cell_i.lane[k].z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

/* hdl/dqz_rotate_back.sv */
// dqz_rotate_back: sine/cosine unfold, rotation products, gain for inverse dq0 and saturation
// depends on dqz_pkg; takes the last cordic cell output
`timescale 1ns / 1ps
module dqz_rotate_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dqz_pkg::dqz_cord_t            chain_i,
  input  logic [dqz_pkg::GAIN_W-1:0]    gain,
  output logic                          out_valid,
  output dqz_pkg::dqz_out_t             out_data
);

  logic                              e1_vld_r, e2_vld_r, e3_vld_r;
  logic [2:0]                        e1_op_r, e2_op_r;
  logic signed [dqz_pkg::P_W-1:0]    e1_p_r [3];
  logic signed [dqz_pkg::COEF_W-1:0] c_r [3];
  logic signed [dqz_pkg::COEF_W-1:0] s_r [3];
  logic signed [dqz_pkg::COEF_W-1:0] c_nxt [3];
  logic signed [dqz_pkg::COEF_W-1:0] s_nxt [3];
  logic signed [dqz_pkg::COEF_W-1:0] cr, sr;
  logic signed [dqz_pkg::SUM_W-1:0]  sum_r [3];
  logic signed [dqz_pkg::SUM_W-1:0]  sum_nxt [3];
  logic signed [dqz_pkg::R_W-1:0]    rr [3];
  logic signed [dqz_pkg::R_W+dqz_pkg::GAIN_W:0] gp [3];
  logic signed [dqz_pkg::R_W+dqz_pkg::GAIN_W:0] v [3];
  logic signed [dqz_pkg::SAMPLE_W-1:0] sat [3];
  logic [2:0]                        clip;
  dqz_pkg::dqz_out_t                 out_r, out_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr = dqz_pkg::clamp_coef(dqz_pkg::rnd(64'(chain_i.lane[k].x), 15));
      sr = dqz_pkg::clamp_coef(dqz_pkg::rnd(64'(chain_i.lane[k].y), 15));
      case (chain_i.lane[k].quad)
        2'd0:    begin c_nxt[k] = cr;  s_nxt[k] = sr;  end
        2'd1:    begin c_nxt[k] = -sr; s_nxt[k] = cr;  end
        2'd2:    begin c_nxt[k] = -cr; s_nxt[k] = -sr; end
        default: begin c_nxt[k] = sr;  s_nxt[k] = -cr; end
      endcase
    end
  end

  always_comb begin
    case (e1_op_r)
      dqz_pkg::OP_PARK, dqz_pkg::OP_IPARK, dqz_pkg::OP_DQZ: begin
        sum_nxt[0] = c_r[0] * e1_p_r[0] + s_r[0] * e1_p_r[1];
        sum_nxt[1] = c_r[0] * e1_p_r[1] - s_r[0] * e1_p_r[0];
        sum_nxt[2] = dqz_pkg::SUM_W'(e1_p_r[2]) <<< 15;
      end
      dqz_pkg::OP_IDQZ: begin
        for (int k = 0; k < 3; k++) begin
          sum_nxt[k] = c_r[k] * e1_p_r[0] - s_r[k] * e1_p_r[1]
                     + dqz_pkg::COEF_INV_SQRT2 * e1_p_r[2];
        end
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          sum_nxt[k] = dqz_pkg::SUM_W'(e1_p_r[k]) <<< 15;
        end
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rr[k] = dqz_pkg::R_W'(dqz_pkg::rnd(64'(sum_r[k]), 15));
      gp[k] = rr[k] * $signed({1'b0, gain});
      v[k]  = (e2_op_r == dqz_pkg::OP_IDQZ) ?
              (dqz_pkg::R_W+dqz_pkg::GAIN_W+1)'(dqz_pkg::rnd(64'(gp[k]), 14)) :
              (dqz_pkg::R_W+dqz_pkg::GAIN_W+1)'(rr[k]);
      if (v[k] > dqz_pkg::SAMPLE_MAX) begin
        sat[k] = dqz_pkg::SAMPLE_MAX; clip[k] = 1'b1;
      end else if (v[k] < dqz_pkg::SAMPLE_MIN) begin
        sat[k] = dqz_pkg::SAMPLE_MIN; clip[k] = 1'b1;
      end else begin
        sat[k] = dqz_pkg::SAMPLE_W'(v[k]); clip[k] = 1'b0;
      end
    end
    if (e2_op_r > dqz_pkg::OP_IDQZ) begin
      out_nxt = '0;
    end else begin
      out_nxt.out_first  = sat[0];
      out_nxt.out_second = sat[1];
      out_nxt.out_third  = sat[2];
      out_nxt.clipped    = |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      e3_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= chain_i.vld;
      e2_vld_r <= e1_vld_r;
      e3_vld_r <= e2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_op_r   <= chain_i.op;
    e1_p_r[0] <= chain_i.p0;
    e1_p_r[1] <= chain_i.p1;
    e1_p_r[2] <= chain_i.p2;
    c_r       <= c_nxt;
    s_r       <= s_nxt;
    e2_op_r   <= e1_op_r;
    sum_r     <= sum_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = e3_vld_r;
  assign out_data  = out_r;

endmodule
